FILE: hw/rtl/fcpm_pkg.sv
`timescale 1ns / 1ps

package fcpm_pkg;

  // palette map codes; code 7 passes the pixel through
  typedef enum logic [2:0] {
    MAP_WHITE  = 3'd0,
    MAP_BLACK  = 3'd1,
    MAP_EXPRED = 3'd2,
    MAP_FIERY  = 3'd3,
    MAP_ORANGE = 3'd4,
    MAP_AZURE  = 3'd5,
    MAP_PURPLE = 3'd6
  } fcpm_map_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_RED_MAP   = 2'd0,
    REG_GREEN_MAP = 2'd1,
    REG_BLUE_MAP  = 2'd2
  } fcpm_reg_e;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } fcpm_pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } fcpm_pix_out_t;

  localparam int unsigned FieryStep = 256 / 3;
  localparam logic [7:0] FieryStep8   = 8'(FieryStep);
  localparam logic [7:0] FieryStep2x8 = 8'(2 * FieryStep);

  localparam logic [7:0] ExpredMin      = 8'd4;
  localparam logic [7:0] ExpredLowGreen = 8'd88;
  localparam logic [7:0] OrangeBlue     = 8'd99;
  localparam logic [7:0] AzureGreenBase = 8'd128;
  localparam logic [7:0] PurpleRedBase  = 8'd112;
  localparam logic [7:0] PurpleGrnBase  = 8'd37;

  // reciprocal multipliers, exact over 0..255
  localparam logic [7:0] Recip3  = 8'd171;   // v/3 = (v*171) >> 9
  localparam logic [8:0] Recip7  = 9'd293;   // v/7 = (v*293) >> 11

  // floor(2^(v/32))
  localparam logic [7:0] ExpTab [256] = '{
    8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
    8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,
    8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
    8'd2,8'd2,8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,
    8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,8'd5,8'd5,
    8'd5,8'd5,8'd5,8'd6,8'd6,8'd6,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd7,8'd7,
    8'd8,8'd8,8'd8,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd9,8'd9,8'd10,8'd10,8'd10,8'd10,8'd11,
    8'd11,8'd11,8'd11,8'd12,8'd12,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd14,8'd14,
    8'd15,8'd15,
    8'd16,8'd16,8'd16,8'd17,8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd19,8'd20,8'd20,8'd21,
    8'd21,8'd22,
    8'd22,8'd23,8'd23,8'd24,8'd24,8'd25,8'd25,8'd26,8'd26,8'd27,8'd28,8'd28,8'd29,8'd29,
    8'd30,8'd31,
    8'd32,8'd32,8'd33,8'd34,8'd34,8'd35,8'd36,8'd37,8'd38,8'd38,8'd39,8'd40,8'd41,8'd42,
    8'd43,8'd44,
    8'd45,8'd46,8'd47,8'd48,8'd49,8'd50,8'd51,8'd52,8'd53,8'd54,8'd56,8'd57,8'd58,8'd59,
    8'd61,8'd62,
    8'd64,8'd65,8'd66,8'd68,8'd69,8'd71,8'd72,8'd74,8'd76,8'd77,8'd79,8'd81,8'd82,8'd84,
    8'd86,8'd88,
    8'd90,8'd92,8'd94,8'd96,8'd98,8'd100,8'd103,8'd105,8'd107,8'd109,8'd112,8'd114,
    8'd117,8'd119,8'd122,8'd125,
    8'd128,8'd130,8'd133,8'd136,8'd139,8'd142,8'd145,8'd148,8'd152,8'd155,8'd158,8'd162,
    8'd165,8'd169,8'd173,8'd177,
    8'd181,8'd184,8'd189,8'd193,8'd197,8'd201,8'd206,8'd210,8'd215,8'd219,8'd224,8'd229,
    8'd234,8'd239,8'd245,8'd250
  };

endpackage

FILE: hw/rtl/false_color_pixel_map.sv
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    in_pix_i   (fcpm_pix_in_t)
// out       output     out_valid_o / out_stall_i  out_pix_o  (fcpm_pix_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// an accepted item goes from the input register through the single pass of
// map logic into the result register, waiting while that one is stalled;
// one item per cycle sustained while out_stall_i is low
// reset clears valid flags and all three map registers to white
// a stalled result holds its register; the input register still empties into
// the result register whenever that one is free, so the input side stalls
// only when both registers are full

module false_color_pixel_map (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  fcpm_pkg::fcpm_pix_in_t in_pix_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output fcpm_pkg::fcpm_pix_out_t out_pix_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [2:0]             cfg_data_i
);
  import fcpm_pkg::*;

  // configuration registers
  logic [2:0] red_map_q, green_map_q, blue_map_q;

  // input register
  logic         s1_valid_q;
  fcpm_pix_in_t s1_pix_q;

  // result register
  logic          out_valid_q;
  fcpm_pix_out_t out_pix_q, out_pix_d;

  logic out_free;   // result register can take an item this cycle
  logic s1_move;    // input register hands its item on
  logic s1_load;    // new item accepted

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign s1_load    = in_valid_i && !in_stall_o;

  // writes beyond the register list fall into the default arm and are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_map_q   <= 3'd0;
      green_map_q <= 3'd0;
      blue_map_q  <= 3'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (fcpm_reg_e'(cfg_index_i))
        REG_RED_MAP:   red_map_q   <= cfg_data_i;
        REG_GREEN_MAP: green_map_q <= cfg_data_i;
        REG_BLUE_MAP:  blue_map_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_pix_q <= in_pix_i;
    end
    if (s1_move) begin
      out_pix_q <= out_pix_d;
    end
  end

  // ---- map logic ----
  logic [7:0]  lvl;        // level taken from the first nonzero channel
  logic [2:0]  code;       // map code of that channel
  logic        all_zero;
  logic [7:0]  e_val;      // exponential of the level
  logic [7:0]  fiery_rem;
  logic [7:0]  fiery_sh;
  logic [15:0] div3_prod;
  logic [16:0] div7_prod;
  logic [7:0]  lvl_div2, lvl_div3, lvl_div7;

  always_comb begin
    all_zero = 1'b0;
    priority if (s1_pix_q.in_red != 8'd0) begin
      lvl  = s1_pix_q.in_red;
      code = red_map_q;
    end else if (s1_pix_q.in_green != 8'd0) begin
      lvl  = s1_pix_q.in_green;
      code = green_map_q;
    end else begin
      lvl      = s1_pix_q.in_blue;
      code     = blue_map_q;
      all_zero = (s1_pix_q.in_blue == 8'd0);
    end
  end

  assign e_val     = ExpTab[lvl];
  assign div3_prod = 16'(lvl) * 16'(Recip3);
  assign div7_prod = 17'(lvl) * 17'(Recip7);
  assign lvl_div2  = {1'b0, lvl[7:1]};
  assign lvl_div3  = 8'(div3_prod >> 9);
  assign lvl_div7  = 8'(div7_prod >> 11);

  // fiery band: below one step, one to two steps, two steps and up
  always_comb begin
    if (e_val >= FieryStep2x8) begin
      fiery_rem = e_val - FieryStep2x8;
    end else if (e_val >= FieryStep8) begin
      fiery_rem = e_val - FieryStep8;
    end else begin
      fiery_rem = e_val;
    end
    fiery_sh = 8'({fiery_rem, 1'b0} + {1'b0, fiery_rem});
  end

  always_comb begin
    if (all_zero) begin
      out_pix_d = '0;
    end else begin
      unique case (fcpm_map_e'(code))
        MAP_WHITE: out_pix_d = '{8'd255, 8'd255, 8'd255};
        MAP_BLACK: out_pix_d = '{8'd0, 8'd0, 8'd0};
        MAP_EXPRED: begin
          if (e_val < ExpredMin) begin
            out_pix_d = '{8'd0, ExpredLowGreen, 8'd255};
          end else begin
            out_pix_d = '{e_val, 8'd0, 8'd0};
          end
        end
        MAP_FIERY: begin
          if (e_val >= FieryStep2x8) begin
            out_pix_d = '{8'd255, 8'd255, fiery_sh};
          end else if (e_val >= FieryStep8) begin
            out_pix_d = '{8'd255, fiery_sh, 8'd0};
          end else begin
            out_pix_d = '{fiery_sh, 8'd0, 8'd0};
          end
        end
        MAP_ORANGE: out_pix_d = '{8'd255, lvl_div2, OrangeBlue};
        MAP_AZURE:  out_pix_d = '{lvl_div3, AzureGreenBase + lvl_div2, 8'd255};
        MAP_PURPLE: out_pix_d = '{PurpleRedBase + lvl_div7,
                                  PurpleGrnBase + lvl_div2, 8'd255};
        // unused code: pixel passes through
        default:    out_pix_d = '{s1_pix_q.in_red, s1_pix_q.in_green, s1_pix_q.in_blue};
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;

  // ---- assertions ----
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled without both registers full");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q)
    else $error("stalled input item lost");

  a_free_slot_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("item not moved into free result register");

  a_black_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move && all_zero |=> out_pix_q == '0)
    else $error("all-zero pixel not passed as black");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fcpm_pkg::*;

  // map code with no palette behind it, the selected pixel passes through
  localparam logic [2:0] MapPassThru = 3'd7;
  // register index past the end of the list, the block drops such writes
  localparam logic [1:0] RegUnused = 2'd3;

  localparam int RandItems  = 1750;
  localparam int TailCycles = 10;
  localparam int CycleLimit = 400000;

  // one entry of the feed: a pixel or a map register write
  typedef struct {
    bit           is_write;
    fcpm_pix_in_t pix;
    logic [1:0]   reg_idx;
    logic [2:0]   map_code;
  } feed_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  fcpm_pix_in_t  in_pix_i    = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  fcpm_pix_out_t out_pix_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = '0;
  logic [2:0]    cfg_data_i  = '0;

  feed_t         feed_q[$];
  fcpm_pix_out_t recolor_q[$];

  // map selection as the testbench believes it to be
  logic [2:0] red_sel   = MAP_WHITE;
  logic [2:0] green_sel = MAP_WHITE;
  logic [2:0] blue_sel  = MAP_WHITE;

  int in_flight = 0;
  int err_cnt   = 0;
  int cycle_cnt = 0;
  int gap_left  = 0;
  int stall_left = 0;
  bit calm_in   = 1'b0;
  bit calm_out  = 1'b0;

  false_color_pixel_map i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pix_i    (in_pix_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pix_o   (out_pix_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // expected recolored pixel for the current map selection
  function automatic fcpm_pix_out_t recolor(fcpm_pix_in_t pix);
    logic [2:0]    sel;
    int unsigned   lvl;
    int unsigned   e;
    int unsigned   tier;
    int unsigned   shade;
    fcpm_pix_out_t res;
    // first nonzero channel picks the map and gives the level
    if (pix.in_red != 0) begin
      sel = red_sel;
      lvl = pix.in_red;
    end else if (pix.in_green != 0) begin
      sel = green_sel;
      lvl = pix.in_green;
    end else if (pix.in_blue != 0) begin
      sel = blue_sel;
      lvl = pix.in_blue;
    end else begin
      // black stays black
      return '0;
    end
    // floor(2^(lvl/32)), exact at the powers of two
    e = int'($floor(2.0 ** (real'(lvl) / 32.0)));
    tier = e / FieryStep;
    shade = ((e - FieryStep * tier) * 3) & 8'hFF;
    case (sel)
      MAP_WHITE: res = '{8'd255, 8'd255, 8'd255};
      MAP_BLACK: res = '{8'd0, 8'd0, 8'd0};
      MAP_EXPRED: begin
        // low exponent values fall back to a blue tone
        if (e < ExpredMin) res = '{8'd0, ExpredLowGreen, 8'd255};
        else res = '{8'(e), 8'd0, 8'd0};
      end
      MAP_FIERY: begin
        // black to red, red to yellow, yellow to white
        if (tier == 0) res = '{8'(shade), 8'd0, 8'd0};
        else if (tier == 1) res = '{8'd255, 8'(shade), 8'd0};
        else res = '{8'd255, 8'd255, 8'(shade)};
      end
      MAP_ORANGE: res = '{8'd255, 8'(lvl / 2), OrangeBlue};
      MAP_AZURE:  res = '{8'(lvl / 3), 8'(AzureGreenBase + lvl / 2), 8'd255};
      MAP_PURPLE: res = '{8'(PurpleRedBase + lvl / 7), 8'(PurpleGrnBase + lvl / 2), 8'd255};
      default:    res = '{pix.in_red, pix.in_green, pix.in_blue};
    endcase
    return res;
  endfunction

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    feed_t f;
    f.is_write = 1'b0;
    f.pix = '{r, g, b};
    f.reg_idx = '0;
    f.map_code = '0;
    feed_q.push_back(f);
  endtask

  task automatic push_write(logic [1:0] idx, logic [2:0] code);
    feed_t f;
    f.is_write = 1'b1;
    f.pix = '0;
    f.reg_idx = idx;
    f.map_code = code;
    feed_q.push_back(f);
  endtask

  // random pixel, weighted so each channel gets to pick the map
  task automatic push_random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: r = 8'($urandom_range(1, 255));
      6, 7, 8, 9, 10, 11: begin
        r = '0;
        g = 8'($urandom_range(1, 255));
      end
      12, 13, 14, 15, 16, 17: begin
        r = '0;
        g = '0;
        b = 8'($urandom_range(1, 255));
      end
      18: begin
        r = '0;
        g = '0;
        b = '0;
      end
      default: ;
    endcase
    push_pixel(r, g, b);
  endtask

  // stimulus, reset, end of run
  initial begin
    int         rand_cnt;
    int         phase;
    int         n;
    logic [2:0] code;

    // all maps still white after reset, stray index write dropped
    push_write(RegUnused, MAP_BLACK);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);

    // exponential, fiery and orange, level extremes and the blue fallback edge
    push_write(REG_RED_MAP, MAP_EXPRED);
    push_write(REG_GREEN_MAP, MAP_FIERY);
    push_write(REG_BLUE_MAP, MAP_ORANGE);
    push_pixel(8'd1, 8'd0, 8'd0);
    push_pixel(8'd63, 8'd0, 8'd0);
    push_pixel(8'd64, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd1, 8'd0);
    push_pixel(8'd0, 8'd200, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd1);
    push_pixel(8'd0, 8'd0, 8'd255);

    // azure, purple, and an unused code on blue
    push_write(REG_RED_MAP, MAP_AZURE);
    push_write(REG_GREEN_MAP, MAP_PURPLE);
    push_write(REG_BLUE_MAP, MapPassThru);
    push_pixel(8'd255, 8'd3, 8'd4);
    push_pixel(8'd1, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd1, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd1);

    // unused code on red, black and white on the others
    push_write(REG_RED_MAP, MapPassThru);
    push_write(REG_GREEN_MAP, MAP_BLACK);
    push_write(REG_BLUE_MAP, MAP_WHITE);
    push_pixel(8'd128, 8'd1, 8'd2);
    push_pixel(8'd0, 8'd128, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd128);
    push_pixel(8'd0, 8'd0, 8'd0);

    // random phases, opened by any map writes drawn for them while the block is drained
    rand_cnt = 0;
    phase = 0;
    while (rand_cnt < RandItems) begin
      if (phase % 5 == 0) begin
        // one extreme setting on all three maps
        case ($urandom_range(0, 2))
          0: code = MAP_WHITE;
          1: code = MAP_PURPLE;
          default: code = MapPassThru;
        endcase
        push_write(REG_RED_MAP, code);
        push_write(REG_GREEN_MAP, code);
        push_write(REG_BLUE_MAP, code);
      end else begin
        if ($urandom_range(0, 3) != 0) push_write(REG_RED_MAP, 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) != 0) push_write(REG_GREEN_MAP, 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) != 0) push_write(REG_BLUE_MAP, 3'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 7) == 0) push_write(RegUnused, 3'($urandom_range(0, 7)));
      n = $urandom_range(40, 200);
      repeat (n) begin
        push_random_pixel();
        rand_cnt++;
      end
      phase++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything sent, everything back
    while (feed_q.size() != 0 || in_valid_i || cfg_valid_i || in_flight != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (recolor_q.size() != 0) begin
      $error("%0d recolored pixels never came out", recolor_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // pixel and register driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic  nxt_valid;
    logic  nxt_cfg;
    feed_t f;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_pix_i <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i <= '0;
      gap_left = 0;
      in_flight = 0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_cfg = cfg_valid_i;
      // pixel taken: predict its result now, with the maps as they stand
      if (in_valid_i && !in_stall_o) begin
        recolor_q.push_back(recolor(in_pix_i));
        in_flight++;
        nxt_valid = 1'b0;
      end
      if (out_valid_o && !out_stall_i) in_flight--;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_RED_MAP:   red_sel = cfg_data_i;
          REG_GREEN_MAP: green_sel = cfg_data_i;
          REG_BLUE_MAP:  blue_sel = cfg_data_i;
          default: ;
        endcase
        nxt_cfg = 1'b0;
      end
      if (!nxt_valid && !nxt_cfg && feed_q.size() != 0) begin
        if (feed_q[0].is_write) begin
          // maps change only once every pixel in flight has come out
          if (in_flight == 0) begin
            f = feed_q.pop_front();
            cfg_index_i <= f.reg_idx;
            cfg_data_i <= f.map_code;
            nxt_cfg = 1'b1;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          f = feed_q.pop_front();
          in_pix_i <= f.pix;
          nxt_valid = 1'b1;
          // gap before the next pixel, with calm stretches of back to back items
          gap_left = calm_in ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
        end
      end
      in_valid_i <= nxt_valid;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // result monitor with random back pressure
  always @(posedge clk_i or negedge rst_ni) begin
    fcpm_pix_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (recolor_q.size() == 0) begin
          $error("unexpected pixel out: %h", out_pix_o);
          err_cnt++;
        end else begin
          want = recolor_q.pop_front();
          if (out_pix_o.out_red !== want.out_red) begin
            $error("out_red: expected %0d, got %0d", want.out_red, out_pix_o.out_red);
            err_cnt++;
          end
          if (out_pix_o.out_green !== want.out_green) begin
            $error("out_green: expected %0d, got %0d", want.out_green, out_pix_o.out_green);
            err_cnt++;
          end
          if (out_pix_o.out_blue !== want.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want.out_blue, out_pix_o.out_blue);
            err_cnt++;
          end
        end
        // cycles to hold off the next result
        stall_left = calm_out ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 63) == 0) calm_out = !calm_out;
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

FILE: files.f
hw/rtl/fcpm_pkg.sv
hw/rtl/false_color_pixel_map.sv
test/testbench.sv
